[rtl/cpbm_pkg.sv]
// ----------------------------------------------------------------------------
// cpbm_pkg
// Shared types and constants for the cartridge PRG bank mapper.
// ----------------------------------------------------------------------------
package cpbm_pkg;

    localparam int ROM_ADDR_BITS_DEF = 22;
    localparam int ROM_ADDR_W        = 22;   // width of the rom_address field
    localparam int IN_TDATA_W        = 32;
    localparam int OUT_TDATA_W       = 48;
    localparam int OUT_TUSER_W       = 4;

    // access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // address decode prefixes
    localparam logic [5:0] REG_WIN_HI    = 6'b010100;  // 0x5000-0x53FF
    localparam logic [5:0] STATUS_WIN_HI = 6'b010101;  // 0x5400-0x57FF
    localparam logic [2:0] WRAM_WIN_HI   = 3'b011;     // 0x6000-0x7FFF

    // bank constants
    localparam logic [4:0] BANK_LAST    = 5'h1F;
    localparam logic [4:0] BANK_1C      = 5'h1C;
    localparam logic [4:0] BANK_1E      = 5'h1E;
    localparam logic [3:0] BANK_LAST_16 = 4'hF;

    localparam logic [7:0] STATUS_EE_LOW = 8'h04;
    localparam logic [7:0] STATUS_EE_HIGH = 8'h00;

    typedef enum logic [1:0] {
        MODE_512K = 2'd0,
        MODE_OPEN = 2'd1,
        MODE_448  = 2'd2,
        MODE_SPLIT = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] r3;
        logic [7:0] r2;
        logic [7:0] r1;
        logic [7:0] r0;
    } t_regs;

    typedef struct packed {
        logic        eeprom_out;
        logic [7:0]  write_data;
        logic [15:0] bus_address;
        logic        func;
    } t_item;

    typedef struct packed {
        logic                  rom_select;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  open_bus;
        logic                  wram_select;
        logic [12:0]           wram_address;
        logic                  read_driven;
        logic [7:0]            read_data;
        logic                  mirror_horizontal;
        logic                  one_bpp_mode;
        logic                  eeprom_select;
        logic                  eeprom_clock;
        logic                  eeprom_data_in;
    } t_result;

endpackage

[rtl/cartridge_prg_bank_mapper_unit.sv]
// ----------------------------------------------------------------------------
// cartridge_prg_bank_mapper_unit
// Cartridge PRG bank mapper: one result beat per CPU bus access.
// ----------------------------------------------------------------------------
// Use:
//   Slave channel (i_s_*) carries one CPU bus access per beat; the access
//   kind (read/write) rides in tuser. Master channel (o_m_*) returns one
//   result beat per access, in order: ROM/WRAM/status selects in tuser,
//   addresses, status byte and mapper pin levels in tdata.
//   Writes to 0x5000-0x53FF load the four mapper bytes; the pin levels in a
//   result already show that access's own write.
// Order: an accepted access waits in the input register, then is translated
//   into the result register, which presents its result beat.
// Throughput: one access per cycle while the sink holds tready high; the
//   only logic between the registers is the byte merge, decode and bank mux.
// Reset: synchronous, active low; both stages empty, mapper bytes zero
//   (512K mode, bank zero).
// Stall: while the sink holds tready low the result register holds, the
//   input register fills, and then o_s_tready drops; nothing is dropped.
// ----------------------------------------------------------------------------
module cartridge_prg_bank_mapper_unit #(
    parameter int ROM_ADDR_BITS = cpbm_pkg::ROM_ADDR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] bus_address, [23:16] write_data, [24] eeprom_out, [31:25] zero
    input  logic [cpbm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] func
    input  logic                             i_s_tuser,
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [21:0] rom_address, [34:22] wram_address, [42:35] read_data,
    // [43] mirror_horizontal, [44] one_bpp_mode, [45] eeprom_select,
    // [46] eeprom_clock, [47] eeprom_data_in
    output logic [cpbm_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [0] rom_select, [1] open_bus, [2] wram_select, [3] read_driven
    output logic [cpbm_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import cpbm_pkg::*;

    // input register stage
    logic    r_in_vld;
    t_item   r_in;
    // result register stage
    logic    r_out_vld;
    t_result r_out;

    logic    adv;        // input register moves into result register
    t_item   n_in;
    t_regs   regs_view;
    t_result res;

    assign adv        = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;

    assign n_in.func        = i_s_tuser;
    assign n_in.bus_address = i_s_tdata[15:0];
    assign n_in.write_data  = i_s_tdata[23:16];
    assign n_in.eeprom_out  = i_s_tdata[24];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= n_in;
        end
    end

    // mapper bytes commit as a beat leaves the input register, so writes and
    // reads see them in bus order
    cpbm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_view  (regs_view)
    );

    cpbm_xlate #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_xlate (
        .i_item (r_in),
        .i_regs (regs_view),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out.eeprom_data_in, r_out.eeprom_clock, r_out.eeprom_select,
                         r_out.one_bpp_mode, r_out.mirror_horizontal, r_out.read_data,
                         r_out.wram_address, r_out.rom_address};
    assign o_m_tuser  = {r_out.read_driven, r_out.wram_select, r_out.open_bus,
                         r_out.rom_select};

endmodule

[rtl/cpbm_regs.sv]
// ----------------------------------------------------------------------------
// cpbm_regs
// Four mapper control bytes, loaded by writes to 0x5000-0x53FF.
// ----------------------------------------------------------------------------
module cpbm_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  cpbm_pkg::t_item  i_item,
    output cpbm_pkg::t_regs  o_view
);
    import cpbm_pkg::*;

    t_regs r_regs;
    t_regs n_regs;
    logic  wr_hit;

    // view seen by the current beat: registers after its own write
    always_comb begin
        wr_hit = (i_item.func == FUNC_WRITE) && (i_item.bus_address[15:10] == REG_WIN_HI);
        n_regs = r_regs;
        if (wr_hit) begin
            case (i_item.bus_address[9:8])
                2'd0:    n_regs.r0 = i_item.write_data;
                2'd1:    n_regs.r1 = i_item.write_data;
                2'd2:    n_regs.r2 = i_item.write_data;
                2'd3:    n_regs.r3 = i_item.write_data;
                default: n_regs = r_regs;
            endcase
        end
    end

    assign o_view = n_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_adv) begin
            r_regs <= n_regs;
        end
    end

endmodule

[rtl/cpbm_xlate.sv]
// ----------------------------------------------------------------------------
// cpbm_xlate
// Address decode and PRG bank translation for one bus access.
// ----------------------------------------------------------------------------
module cpbm_xlate #(
    parameter int ROM_ADDR_BITS = cpbm_pkg::ROM_ADDR_BITS_DEF
) (
    input  cpbm_pkg::t_item   i_item,
    input  cpbm_pkg::t_regs   i_regs,
    output cpbm_pkg::t_result o_res
);
    import cpbm_pkg::*;

    localparam logic [ROM_ADDR_W-1:0] ROM_MASK =
        ROM_ADDR_W'((23'd1 << ROM_ADDR_BITS) - 23'd1);

    logic [4:0]            low;
    logic [7:0]            high;
    t_mode                 mode;
    logic                  upper;
    logic [7:0]            bank;
    logic [7:0]            b32;
    logic [7:0]            bsplit;
    logic [22:0]           raw;
    logic                  rom_rd;
    logic                  status_rd;

    always_comb begin
        low    = {i_regs.r0[5], i_regs.r0[3:0]};
        high   = {i_regs.r1[2:0], 5'd0};
        mode   = t_mode'({i_regs.r0[6], i_regs.r0[4]});
        upper  = i_item.bus_address[14];
        b32    = {1'b0, i_regs.r1[2:0], 4'd0} | {3'd0, low};
        bsplit = high | {3'd0, low[3], 4'd0};
        bank   = '0;
        raw    = '0;

        case (mode)
            MODE_512K: begin
                bank = upper ? (high | {3'd0, BANK_LAST}) : (high | {3'd0, low});
                raw  = {1'b0, bank, i_item.bus_address[13:0]};
            end
            MODE_448: begin
                bank = upper ? (high | {3'd0, (low >= BANK_1C) ? BANK_1C : BANK_1E})
                             : (high | {3'd0, low});
                raw  = {1'b0, bank, i_item.bus_address[13:0]};
            end
            MODE_SPLIT: begin
                if (low[4]) begin
                    bank = upper ? (bsplit | {4'd0, BANK_LAST_16})
                                 : (bsplit | {4'd0, low[3:0]});
                    raw  = {1'b0, bank, i_item.bus_address[13:0]};
                end else begin
                    raw  = {b32, i_item.bus_address[14:0]};
                end
            end
            default: begin
                bank = '0;
                raw  = '0;
            end
        endcase

        rom_rd    = (i_item.func == FUNC_READ) && i_item.bus_address[15];
        status_rd = (i_item.func == FUNC_READ)
                    && (i_item.bus_address[15:10] == STATUS_WIN_HI);

        o_res.rom_select   = rom_rd && (mode != MODE_OPEN);
        o_res.rom_address  = o_res.rom_select ? (raw[ROM_ADDR_W-1:0] & ROM_MASK) : '0;
        o_res.open_bus     = rom_rd && (mode == MODE_OPEN);
        o_res.wram_select  = (i_item.bus_address[15:13] == WRAM_WIN_HI);
        o_res.wram_address = o_res.wram_select ? i_item.bus_address[12:0] : '0;
        o_res.read_driven  = status_rd;
        o_res.read_data    = !status_rd ? 8'd0
                             : (i_item.eeprom_out ? STATUS_EE_HIGH : STATUS_EE_LOW);
        o_res.mirror_horizontal = i_regs.r0[4] && !i_regs.r3[7];
        o_res.one_bpp_mode      = i_regs.r0[7];
        o_res.eeprom_select     = i_regs.r2[4];
        o_res.eeprom_clock      = i_regs.r2[2];
        o_res.eeprom_data_in    = i_regs.r2[0];
    end

endmodule

[verif/tb_cartridge_prg_bank_mapper_unit.sv]
// ----------------------------------------------------------------------------
// tb_cartridge_prg_bank_mapper_unit
// Self-checking bench for the PRG bank mapper. CPU bus accesses go in on the
// slave stream. A local model of the four mapper bytes works out each result
// beat, and every beat that comes out is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_cartridge_prg_bank_mapper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cpbm_pkg::*;

    localparam int ROM_BITS     = ROM_ADDR_BITS_DEF;
    localparam int CYCLE_LIMIT  = 200000;   // watchdog limit
    localparam int RANDOM_BEATS = 925;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;      // [15:0] bus_address, [23:16] write_data,
                                            // [24] eeprom_out, [31:25] zero
    logic                   i_s_tuser;      // [0] func
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;      // [21:0] rom_address, [34:22] wram_address,
                                            // [42:35] read_data, [43] mirror_horizontal,
                                            // [44] one_bpp_mode, [45] eeprom_select,
                                            // [46] eeprom_clock, [47] eeprom_data_in
    logic [OUT_TUSER_W-1:0] o_m_tuser;      // [0] rom_select, [1] open_bus,
                                            // [2] wram_select, [3] read_driven

    // local copy of the mapper bytes and the translations still to come out
    logic [7:0]  bank_regs [4];
    t_result     mapped_q [$];

    bit          steady;                    // no idling on either side while set
    int unsigned error_count;
    int unsigned access_count;
    int unsigned reg_load_count;
    int unsigned beat_count;
    int unsigned mode_hits [4];
    int unsigned cycle_count;

    cartridge_prg_bank_mapper_unit #(
        .ROM_ADDR_BITS(ROM_BITS)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Translation of one access. Register write lands first, so the pin
    // levels and the bank used for this access already reflect it.
    // ------------------------------------------------------------------------
    function automatic t_result map_access(input t_item acc);
        t_result     res;
        logic [7:0]  r0;
        logic [4:0]  low;
        logic [7:0]  high;
        logic [7:0]  bank;
        logic [7:0]  wide_bank;
        logic [22:0] wide_addr;
        t_mode       mode;
        logic        upper;
        logic        is_read;

        res     = '0;
        is_read = (acc.func == FUNC_READ);
        if (!is_read && acc.bus_address >= 16'h5000 && acc.bus_address <= 16'h53FF) begin
            bank_regs[acc.bus_address[9:8]] = acc.write_data;
            reg_load_count++;
        end

        r0    = bank_regs[0];
        low   = {r0[5], r0[3:0]};
        high  = {bank_regs[1][2:0], 5'b0};
        mode  = t_mode'({r0[6], r0[4]});
        upper = acc.bus_address[14];

        if (is_read && acc.bus_address[15]) begin
            mode_hits[mode]++;
            res.rom_select = 1'b1;
            wide_addr      = '0;
            case (mode)
                MODE_512K: begin
                    bank      = upper ? (high | {3'b0, BANK_LAST}) : (high | {3'b0, low});
                    wide_addr = {1'b0, bank, acc.bus_address[13:0]};
                end
                MODE_448: begin
                    if (upper)
                        bank = high | {3'b0, (low >= BANK_1C) ? BANK_1C : BANK_1E};
                    else
                        bank = high | {3'b0, low};
                    wide_addr = {1'b0, bank, acc.bus_address[13:0]};
                end
                MODE_SPLIT: begin
                    if (low[4]) begin
                        // two 16K banks, low bit3 moves up to bit4
                        bank = high | {3'b0, low[3], 4'b0};
                        bank = upper ? (bank | {4'b0, BANK_LAST_16}) : (bank | {4'b0, low[3:0]});
                        wide_addr = {1'b0, bank, acc.bus_address[13:0]};
                    end else begin
                        // one 32K bank
                        wide_bank = (high >> 1) | {3'b0, low};
                        wide_addr = {wide_bank, acc.bus_address[14:0]};
                    end
                end
                default: begin
                    res.rom_select = 1'b0;
                    res.open_bus   = 1'b1;
                end
            endcase
            if (res.rom_select)
                res.rom_address = wide_addr[ROM_ADDR_W-1:0] & ((22'd1 << ROM_BITS) - 22'd1);
        end

        if (acc.bus_address[15:13] == 3'b011) begin
            res.wram_select  = 1'b1;
            res.wram_address = acc.bus_address[12:0];
        end

        if (is_read && acc.bus_address >= 16'h5400 && acc.bus_address <= 16'h57FF) begin
            res.read_driven = 1'b1;
            res.read_data   = acc.eeprom_out ? STATUS_EE_HIGH : STATUS_EE_LOW;
        end

        res.mirror_horizontal = bank_regs[0][4] & ~bank_regs[3][7];
        res.one_bpp_mode      = bank_regs[0][7];
        res.eeprom_select     = bank_regs[2][4];
        res.eeprom_clock      = bank_regs[2][2];
        res.eeprom_data_in    = bank_regs[2][0];
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
                                      beat_count, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // One access beat. Valid stays high across back-to-back beats; it only
    // drops when an idle gap is drawn.
    // ------------------------------------------------------------------------
    task automatic send_access(input logic kind, input logic [15:0] addr,
                               input logic [7:0] data, input logic ee);
        int unsigned gap;
        bit          took;
        t_item       acc;

        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, ee, data, addr};
        i_s_tuser  <= kind;
        do begin
            @(negedge i_clk);
            took = o_s_tready;
            @(posedge i_clk);
        end while (!took);

        acc.func        = kind;
        acc.bus_address = addr;
        acc.write_data  = data;
        acc.eeprom_out  = ee;
        mapped_q.push_back(map_access(acc));
        access_count++;
    endtask

    function automatic logic rand_bit();
        return logic'($urandom_range(0, 1));
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // 512K mode, bank zero; upper half is the last bank
        send_access(FUNC_READ, 16'h8000, 8'h00, 1'b1);
        send_access(FUNC_READ, 16'hFFFF, 8'hFF, 1'b0);
    endtask

    task automatic test_register_loads();
        send_access(FUNC_WRITE, 16'h5000, 8'hFF, 1'b0);    // all mode bits, 1bpp
        send_access(FUNC_WRITE, 16'h51FF, 8'hFF, 1'b1);    // top high bank
        send_access(FUNC_WRITE, 16'h52FF, 8'hFF, 1'b0);    // all EEPROM pins up
        send_access(FUNC_WRITE, 16'h53FF, 8'h80, 1'b1);    // mirroring forced vertical
    endtask

    task automatic test_rom_modes();
        // split mode, two 16K banks
        send_access(FUNC_READ, 16'h8000, 8'h00, 1'b0);
        send_access(FUNC_READ, 16'hC000, 8'h00, 1'b1);
        // 448+64 with low bank below 0x1C, then at 0x1C
        send_access(FUNC_WRITE, 16'h5000, 8'h40, 1'b0);
        send_access(FUNC_READ, 16'hC000, 8'h55, 1'b0);
        send_access(FUNC_WRITE, 16'h5000, 8'h6C, 1'b1);
        send_access(FUNC_READ, 16'hFFFF, 8'h00, 1'b1);
        // open bus
        send_access(FUNC_WRITE, 16'h5000, 8'h10, 1'b0);
        send_access(FUNC_READ, 16'h9234, 8'h00, 1'b0);
        // split mode, one 32K bank
        send_access(FUNC_WRITE, 16'h5000, 8'h53, 1'b0);
        send_access(FUNC_READ, 16'hABCD, 8'h00, 1'b1);
    endtask

    task automatic test_port_decode();
        send_access(FUNC_WRITE, 16'h5400, 8'hAA, 1'b0);    // status write: no effect
        send_access(FUNC_READ,  16'h5400, 8'h00, 1'b0);    // EEPROM bit low
        send_access(FUNC_READ,  16'h57FF, 8'h00, 1'b1);    // EEPROM bit high
        send_access(FUNC_READ,  16'h5000, 8'h00, 1'b1);    // register read: not driven
        send_access(FUNC_WRITE, 16'h8000, 8'h00, 1'b0);    // ROM write: dropped
        send_access(FUNC_WRITE, 16'h6000, 8'h12, 1'b1);
        send_access(FUNC_READ,  16'h7FFF, 8'h00, 1'b0);
        send_access(FUNC_READ,  16'h0000, 8'h00, 1'b0);
        send_access(FUNC_READ,  16'h5FFF, 8'h00, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly a mapper byte write followed by a burst of ROM reads,
    // plus status, WRAM and fully random accesses as noise.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned chunk;
        int unsigned pick;
        int unsigned burst;

        stop_at = access_count + RANDOM_BEATS;
        chunk   = 0;
        while (access_count < stop_at) begin
            steady = (chunk % 4 == 3);
            for (int k = 0; (k < 40) && (access_count < stop_at); k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    send_access(FUNC_WRITE,
                                16'h5000 | 16'($urandom_range(0, 16'h03FF)),
                                8'($urandom), rand_bit());
                    burst = $urandom_range(1, 4);
                    repeat (burst)
                        send_access(FUNC_READ,
                                    16'h8000 | 16'($urandom_range(0, 16'h7FFF)),
                                    8'($urandom), rand_bit());
                end else if (pick < 60) begin
                    send_access(rand_bit(), 16'h5400 | 16'($urandom_range(0, 16'h03FF)),
                                8'($urandom), rand_bit());
                end else if (pick < 75) begin
                    send_access(rand_bit(), 16'h6000 | 16'($urandom_range(0, 16'h1FFF)),
                                8'($urandom), rand_bit());
                end else begin
                    send_access(rand_bit(), 16'($urandom), 8'($urandom), rand_bit());
                end
            end
            chunk++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sink: per beat, draw a stall, then hold ready until a beat is taken.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        bit          took;

        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                took = o_m_tvalid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    // Result beats are picked off at the falling edge: ready and valid only
    // move at the rising edge, so what is seen here is what the next edge takes.
    initial begin : result_check
        t_result got;
        t_result want;

        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.rom_address       = o_m_tdata[21:0];
                got.wram_address      = o_m_tdata[34:22];
                got.read_data         = o_m_tdata[42:35];
                got.mirror_horizontal = o_m_tdata[43];
                got.one_bpp_mode      = o_m_tdata[44];
                got.eeprom_select     = o_m_tdata[45];
                got.eeprom_clock      = o_m_tdata[46];
                got.eeprom_data_in    = o_m_tdata[47];
                got.rom_select        = o_m_tuser[0];
                got.open_bus          = o_m_tuser[1];
                got.wram_select       = o_m_tuser[2];
                got.read_driven       = o_m_tuser[3];
                if (mapped_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, tdata 0x%0h tuser 0x%0h",
                                              o_m_tdata, o_m_tuser));
                end else begin
                    want = mapped_q.pop_front();
                    check_field("rom_select",        got.rom_select,        want.rom_select);
                    check_field("rom_address",       got.rom_address,       want.rom_address);
                    check_field("open_bus",          got.open_bus,          want.open_bus);
                    check_field("wram_select",       got.wram_select,       want.wram_select);
                    check_field("wram_address",      got.wram_address,      want.wram_address);
                    check_field("read_driven",       got.read_driven,       want.read_driven);
                    check_field("read_data",         got.read_data,         want.read_data);
                    check_field("mirror_horizontal", got.mirror_horizontal,
                                want.mirror_horizontal);
                    check_field("one_bpp_mode",      got.one_bpp_mode,      want.one_bpp_mode);
                    check_field("eeprom_select",     got.eeprom_select,     want.eeprom_select);
                    check_field("eeprom_clock",      got.eeprom_clock,      want.eeprom_clock);
                    check_field("eeprom_data_in",    got.eeprom_data_in,    want.eeprom_data_in);
                end
                beat_count++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, mapped_q.size());
            $display("tb_cartridge_prg_bank_mapper_unit: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_flow
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= FUNC_READ;
        steady      = 1'b0;
        error_count = 0;
        access_count   = 0;
        reg_load_count = 0;
        beat_count  = 0;
        cycle_count = 0;
        foreach (bank_regs[i]) bank_regs[i] = 8'h00;
        foreach (mode_hits[i]) mode_hits[i] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_loads();
        test_rom_modes();
        test_port_decode();
        test_random_traffic();

        i_s_tvalid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);    // two-stage pipe, plus margin

        $display("covered %0d accesses (%0d register loads), %0d beats checked",
                 access_count, reg_load_count, beat_count);
        $display("ROM reads per mode: 512K %0d, open %0d, 448+64 %0d, split %0d",
                 mode_hits[MODE_512K], mode_hits[MODE_OPEN],
                 mode_hits[MODE_448], mode_hits[MODE_SPLIT]);
        if (error_count == 0)
            $display("tb_cartridge_prg_bank_mapper_unit: clean");
        else
            $display("tb_cartridge_prg_bank_mapper_unit: errors");
        $finish;
    end

endmodule
